>>> rtl/assert_macros.svh
// Assertion helpers for the button conditioner.
// Each property is checked on the rising edge of clk_i and is switched off
// while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_SAME(lbl, ante, cons, msg)

`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/abc_pkg.sv
package abc_pkg;

  localparam int TIME_BITS = 32;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [7:0]           btn_t;

  // Bit positions in the button vector.
  localparam int BTN_UP    = 0;
  localparam int BTN_DOWN  = 1;
  localparam int BTN_FIRE  = 4;
  localparam int BTN_START = 5;
  localparam int BTN_COIN  = 6;
  localparam int BTN_EXTRA = 7;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_COIN_DIRECT  = 3'd0,
    CFG_COIN_PULSE   = 3'd1,
    CFG_RESET_HOLD   = 3'd2,
    CFG_TURBO_PERIOD = 3'd3,
    CFG_MENU_ENABLE  = 3'd4
  } cfg_idx_e;

  localparam logic [15:0] COIN_PULSE_RST   = 16'd200;
  localparam logic [15:0] RESET_HOLD_RST   = 16'd3000;
  localparam logic [9:0]  TURBO_PERIOD_RST = 10'd50;

  // Flags from the volume and menu logic.
  typedef struct packed {
    logic vol_event;
    logic vol_up;
    logic vol_down;
    logic vol_bar;
    logic attract;
    logic reset_req;
  } ctrl_flags_t;

  function automatic time_t elapsed(time_t now, time_t then);
    return now - then;
  endfunction

endpackage

>>> rtl/abc_coin.sv
module abc_coin (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 coin_direct_i,
  input  logic                 extra_i,
  input  abc_pkg::time_t       now_i,
  input  logic [15:0]          pulse_ms_i,
  output logic                 vcoin_o
);
  import abc_pkg::*;

  typedef enum logic [1:0] {
    COIN_IDLE  = 2'd0,
    COIN_PULSE = 2'd1,
    COIN_WAIT  = 2'd2
  } coin_state_e;

  coin_state_e phase_q, phase_d;
  time_t       time_q, time_d;

  always_comb begin
    phase_d = phase_q;
    time_d  = time_q;
    if (!coin_direct_i) begin
      unique case (phase_q)
        COIN_PULSE: begin
          if (elapsed(now_i, time_q) > time_t'(pulse_ms_i)) begin
            phase_d = COIN_WAIT;
            time_d  = now_i;
          end
        end
        COIN_WAIT: begin
          if (!extra_i) begin
            phase_d = COIN_IDLE;
          end
        end
        default: begin
          // The unused phase code behaves as idle.
          if (extra_i) begin
            phase_d = COIN_PULSE;
            time_d  = now_i;
          end else begin
            phase_d = COIN_IDLE;
          end
        end
      endcase
    end
  end

  assign vcoin_o = !coin_direct_i && (phase_d == COIN_PULSE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= COIN_IDLE;
      time_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      time_q  <= time_d;
    end
  end

endmodule

>>> rtl/abc_ctrl.sv
module abc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 menu_enable_i,
  input  abc_pkg::btn_t        buttons_i,
  input  abc_pkg::time_t       now_i,
  input  logic [15:0]          hold_ms_i,
  output abc_pkg::ctrl_flags_t flags_o
);
  import abc_pkg::*;

  time_t hold_time_q, hold_time_d;
  logic  armed_q, armed_d;
  btn_t  prev_q, prev_d;
  logic  armed_mid;
  logic  vol_hit;

  always_comb begin
    flags_o           = '0;
    flags_o.vol_event = buttons_i[BTN_COIN];
    flags_o.vol_up    = buttons_i[BTN_COIN] && buttons_i[BTN_UP];
    flags_o.vol_down  = buttons_i[BTN_COIN] && buttons_i[BTN_DOWN];
    vol_hit           = flags_o.vol_up || flags_o.vol_down;
    flags_o.vol_bar   = vol_hit;
    // A volume change drops the hold timer even when the menu is off.
    armed_mid         = vol_hit ? 1'b0 : armed_q;

    armed_d     = armed_mid;
    hold_time_d = hold_time_q;
    prev_d      = prev_q;
    if (menu_enable_i) begin
      flags_o.attract = (buttons_i[BTN_UP] && !prev_q[BTN_UP]) ||
                        (buttons_i[BTN_DOWN] && !prev_q[BTN_DOWN]) ||
                        (buttons_i[BTN_EXTRA] && !prev_q[BTN_EXTRA]);
      if (buttons_i[BTN_EXTRA] && buttons_i[BTN_START]) begin
        armed_d = 1'b1;
        if (!armed_mid) begin
          hold_time_d = now_i;
        end
        flags_o.reset_req = elapsed(now_i, hold_time_d) > time_t'(hold_ms_i);
      end else begin
        armed_d = 1'b0;
      end
      prev_d = buttons_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_time_q <= '0;
      armed_q     <= 1'b0;
      prev_q      <= '0;
    end else if (step_i) begin
      hold_time_q <= hold_time_d;
      armed_q     <= armed_d;
      prev_q      <= prev_d;
    end
  end

endmodule

>>> rtl/abc_turbo.sv
module abc_turbo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  abc_pkg::btn_t        merged_i,
  input  abc_pkg::time_t       now_i,
  input  logic [9:0]           period_ms_i,
  output abc_pkg::btn_t        buttons_o,
  output logic                 coin_anim_o
);
  import abc_pkg::*;

  logic  prev_coin_q;
  logic  phase_q, phase_d;
  time_t toggle_q, toggle_d;

  always_comb begin
    phase_d   = phase_q;
    toggle_d  = toggle_q;
    buttons_o = merged_i;
    if (merged_i[BTN_FIRE]) begin
      if (elapsed(now_i, toggle_q) >= time_t'(period_ms_i)) begin
        phase_d  = !phase_q;
        toggle_d = now_i;
      end
      if (!phase_d) begin
        buttons_o[BTN_FIRE] = 1'b0;
      end
    end
  end

  assign coin_anim_o = merged_i[BTN_COIN] && !prev_coin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_coin_q <= 1'b0;
      phase_q     <= 1'b1;
      toggle_q    <= '0;
    end else if (step_i) begin
      prev_coin_q <= merged_i[BTN_COIN];
      phase_q     <= phase_d;
      toggle_q    <= toggle_d;
    end
  end

endmodule

>>> rtl/arcade_button_conditioner_top.sv
// Arcade button conditioner.
// Input channel: in_valid_i / in_stall_o carry one poll per item: the merged
// button vector and a free-running millisecond time. Output channel:
// out_valid_o / out_stall_i carry one result item per poll: the conditioned
// buttons plus volume, attract, reset-request and coin-animation flags.
// An item moves on each rising edge with valid high and stall low.
// A poll is held in an input register, processed by one pass of logic
// through the coin, menu and turbo units, and lands in the result register.
// One item is taken every cycle as long as the receiver keeps taking results.
// When the receiver stalls, the result register holds its item and the
// input register takes one more; after that in_stall_o rises.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at the
// next edge and are meant to be made while no item is in flight.
// Reset clears both valid flags, restores the register defaults and returns
// all unit state to idle with the turbo phase letting FIRE through.
module arcade_button_conditioner_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           buttons_in_i,
  input  logic [31:0]          now_ms_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           buttons_out_o,
  output logic                 volume_event_o,
  output logic                 volume_up_o,
  output logic                 volume_down_o,
  output logic                 volume_bar_show_o,
  output logic                 attract_reset_o,
  output logic                 reset_request_o,
  output logic                 coin_anim_o
);
  import abc_pkg::*;

  `include "assert_macros.svh"

  logic        coin_direct_q;
  logic [15:0] coin_pulse_q;
  logic [15:0] reset_hold_q;
  logic [9:0]  turbo_period_q;
  logic        menu_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coin_direct_q  <= 1'b0;
      coin_pulse_q   <= COIN_PULSE_RST;
      reset_hold_q   <= RESET_HOLD_RST;
      turbo_period_q <= TURBO_PERIOD_RST;
      menu_enable_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_COIN_DIRECT:  coin_direct_q  <= cfg_data_i[0];
        CFG_COIN_PULSE:   coin_pulse_q   <= cfg_data_i;
        CFG_RESET_HOLD:   reset_hold_q   <= cfg_data_i;
        CFG_TURBO_PERIOD: turbo_period_q <= cfg_data_i[9:0];
        CFG_MENU_ENABLE:  menu_enable_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic  in_valid_q;
  btn_t  btn_q;
  time_t now_q;
  logic  step;
  logic  in_take;

  assign step       = in_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      btn_q <= buttons_in_i;
      now_q <= now_ms_i[TIME_BITS-1:0];
    end
  end

  logic        vcoin;
  ctrl_flags_t flags;
  btn_t        merged;
  btn_t        btn_final;
  logic        anim;

  abc_coin u_coin (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .coin_direct_i (coin_direct_q),
    .extra_i       (btn_q[BTN_EXTRA]),
    .now_i         (now_q),
    .pulse_ms_i    (coin_pulse_q),
    .vcoin_o       (vcoin)
  );

  abc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .menu_enable_i (menu_enable_q),
    .buttons_i     (btn_q),
    .now_i         (now_q),
    .hold_ms_i     (reset_hold_q),
    .flags_o       (flags)
  );

  always_comb begin
    merged           = btn_q;
    merged[BTN_COIN] = btn_q[BTN_COIN] || vcoin;
  end

  abc_turbo u_turbo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .merged_i    (merged),
    .now_i       (now_q),
    .period_ms_i (turbo_period_q),
    .buttons_o   (btn_final),
    .coin_anim_o (anim)
  );

  // Result register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      buttons_out_o     <= btn_final;
      volume_event_o    <= flags.vol_event;
      volume_up_o       <= flags.vol_up;
      volume_down_o     <= flags.vol_down;
      volume_bar_show_o <= flags.vol_bar;
      attract_reset_o   <= flags.attract;
      reset_request_o   <= flags.reset_req;
      coin_anim_o       <= anim;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_SAME(a_stall_needs_item, in_stall_o, in_valid_q && out_valid_q, "input stalled while a stage is empty")
  `ASSERT_NEXT(a_step_fills_out, step, out_valid_q, "processed item did not reach the result register")
  `ASSERT_SAME(a_vol_flags, out_valid_q && (volume_up_o || volume_down_o), volume_event_o && volume_bar_show_o, "volume direction without volume event")
  `ASSERT_SAME(a_anim_has_coin, out_valid_q && coin_anim_o, buttons_out_o[BTN_COIN], "coin animation without coin bit")

endmodule

>>> test/tb_arcade_button_conditioner_top.sv
module tb_arcade_button_conditioner_top;
  timeunit 1ns;
  timeprecision 1ps;

  import abc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 60;
  localparam int N_PHASES    = 8;
  localparam int PHASE_POLLS = 105;

  typedef enum logic [1:0] {
    COIN_IDLE     = 2'd0,
    COIN_PULSING  = 2'd1,
    COIN_WAIT_REL = 2'd2,
    COIN_UNUSED   = 2'd3
  } coin_phase_e;

  typedef struct packed {
    btn_t buttons;
    logic vol_event;
    logic vol_up;
    logic vol_down;
    logic vol_bar;
    logic attract;
    logic reset_req;
    logic coin_anim;
  } poll_result_t;

  class poll_scoreboard;
    logic        coin_direct;
    logic [15:0] coin_pulse;
    logic [15:0] hold_ms;
    logic [9:0]  turbo_ms;
    logic        menu_en;

    coin_phase_e coin_phase;
    time_t       coin_time;
    time_t       hold_time;
    logic        hold_armed;
    btn_t        prev_buttons;
    logic        prev_coin_out;
    logic        fire_phase;
    time_t       fire_time;

    poll_result_t expected_polls[$];
    int errors;
    int checked;

    function new();
      coin_direct   = 1'b0;
      coin_pulse    = COIN_PULSE_RST;
      hold_ms       = RESET_HOLD_RST;
      turbo_ms      = TURBO_PERIOD_RST;
      menu_en       = 1'b1;
      coin_phase    = COIN_IDLE;
      coin_time     = '0;
      hold_time     = '0;
      hold_armed    = 1'b0;
      prev_buttons  = '0;
      prev_coin_out = 1'b0;
      fire_phase    = 1'b1;
      fire_time     = '0;
      errors        = 0;
      checked       = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] value);
      case (idx)
        CFG_COIN_DIRECT:  coin_direct = value[0];
        CFG_COIN_PULSE:   coin_pulse  = value;
        CFG_RESET_HOLD:   hold_ms     = value;
        CFG_TURBO_PERIOD: turbo_ms    = value[9:0];
        CFG_MENU_ENABLE:  menu_en     = value[0];
        default: ;
      endcase
    endfunction

    function time_t ms_since(time_t now, time_t then);
      time_t diff;
      diff = now - then;
      return diff;
    endfunction

    function poll_result_t predict_poll(btn_t b, time_t now);
      poll_result_t r;
      btn_t         fin;
      logic         vcoin;
      r     = '0;
      vcoin = 1'b0;

      // The virtual coin machine is frozen while coins arrive directly.
      if (!coin_direct) begin
        case (coin_phase)
          COIN_PULSING: begin
            if (ms_since(now, coin_time) > coin_pulse) begin
              coin_phase = COIN_WAIT_REL;
              coin_time  = now;
            end
          end
          COIN_WAIT_REL: begin
            if (!b[BTN_EXTRA]) coin_phase = COIN_IDLE;
          end
          default: begin
            if (b[BTN_EXTRA]) begin
              coin_phase = COIN_PULSING;
              coin_time  = now;
            end else begin
              coin_phase = COIN_IDLE;
            end
          end
        endcase
        vcoin = (coin_phase == COIN_PULSING);
      end

      if (b[BTN_COIN]) begin
        r.vol_event = 1'b1;
        r.vol_up    = b[BTN_UP];
        r.vol_down  = b[BTN_DOWN];
        if (b[BTN_UP] || b[BTN_DOWN]) begin
          r.vol_bar  = 1'b1;
          hold_armed = 1'b0;
        end
      end

      if (menu_en) begin
        if ((b[BTN_UP] && !prev_buttons[BTN_UP]) || (b[BTN_DOWN] && !prev_buttons[BTN_DOWN]) ||
            (b[BTN_EXTRA] && !prev_buttons[BTN_EXTRA]))
          r.attract = 1'b1;
        if (b[BTN_EXTRA] && b[BTN_START]) begin
          if (!hold_armed) begin
            hold_armed = 1'b1;
            hold_time  = now;
          end
          if (ms_since(now, hold_time) > hold_ms) r.reset_req = 1'b1;
        end else begin
          hold_armed = 1'b0;
        end
        prev_buttons = b;
      end

      fin = b;
      fin[BTN_COIN] = b[BTN_COIN] | vcoin;
      r.coin_anim   = fin[BTN_COIN] && !prev_coin_out;
      prev_coin_out = fin[BTN_COIN];

      if (fin[BTN_FIRE]) begin
        if (ms_since(now, fire_time) >= turbo_ms) begin
          fire_phase = !fire_phase;
          fire_time  = now;
        end
        if (!fire_phase) fin[BTN_FIRE] = 1'b0;
      end
      r.buttons = fin;
      return r;
    endfunction

    function void note_poll(btn_t b, time_t now);
      expected_polls.push_back(predict_poll(b, now));
    endfunction

    function int pending();
      return expected_polls.size();
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_poll_result(poll_result_t got);
      poll_result_t want;
      string        bad;
      bad = "";
      if (expected_polls.size() == 0) begin
        report_mismatch($sformatf("result with no poll pending, buttons_out=%h", got.buttons));
        return;
      end
      want = expected_polls.pop_front();
      checked++;
      if (got.buttons !== want.buttons)
        bad = {bad, $sformatf(" buttons_out %h/%h", got.buttons, want.buttons)};
      if (got.vol_event !== want.vol_event)
        bad = {bad, $sformatf(" volume_event %b/%b", got.vol_event, want.vol_event)};
      if (got.vol_up !== want.vol_up)
        bad = {bad, $sformatf(" volume_up %b/%b", got.vol_up, want.vol_up)};
      if (got.vol_down !== want.vol_down)
        bad = {bad, $sformatf(" volume_down %b/%b", got.vol_down, want.vol_down)};
      if (got.vol_bar !== want.vol_bar)
        bad = {bad, $sformatf(" volume_bar_show %b/%b", got.vol_bar, want.vol_bar)};
      if (got.attract !== want.attract)
        bad = {bad, $sformatf(" attract_reset %b/%b", got.attract, want.attract)};
      if (got.reset_req !== want.reset_req)
        bad = {bad, $sformatf(" reset_request %b/%b", got.reset_req, want.reset_req)};
      if (got.coin_anim !== want.coin_anim)
        bad = {bad, $sformatf(" coin_anim %b/%b", got.coin_anim, want.coin_anim)};
      if (bad != "") report_mismatch($sformatf("result %0d (got/want):%s", checked, bad));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [2:0]  cfg_idx_i    = '0;
  logic [15:0] cfg_data_i   = '0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [7:0]  buttons_in_i = '0;
  logic [31:0] now_ms_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [7:0]  buttons_out_o;
  logic        volume_event_o;
  logic        volume_up_o;
  logic        volume_down_o;
  logic        volume_bar_show_o;
  logic        attract_reset_o;
  logic        reset_request_o;
  logic        coin_anim_o;

  poll_scoreboard sb = new();

  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    holds_asked = 0;
  int    holds_taken = 0;
  int    hold_left = 0;
  int    cycles = 0;
  time_t t_ms = '0;

  arcade_button_conditioner_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .buttons_in_i      (buttons_in_i),
    .now_ms_i          (now_ms_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .buttons_out_o     (buttons_out_o),
    .volume_event_o    (volume_event_o),
    .volume_up_o       (volume_up_o),
    .volume_down_o     (volume_down_o),
    .volume_bar_show_o (volume_bar_show_o),
    .attract_reset_o   (attract_reset_o),
    .reset_request_o   (reset_request_o),
    .coin_anim_o       (coin_anim_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Both channels are sampled at the edge, before any update of that edge lands.
  always @(posedge clk_i) begin
    poll_result_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_poll(buttons_in_i, now_ms_i);
      if (out_valid_o && !out_stall_i) begin
        got.buttons   = buttons_out_o;
        got.vol_event = volume_event_o;
        got.vol_up    = volume_up_o;
        got.vol_down  = volume_down_o;
        got.vol_bar   = volume_bar_show_o;
        got.attract   = attract_reset_o;
        got.reset_req = reset_request_o;
        got.coin_anim = coin_anim_o;
        sb.check_poll_result(got);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is asked for.
  initial begin
    forever begin
      @(posedge clk_i);
      if (holds_taken != holds_asked) begin
        holds_taken = holds_asked;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_poll(btn_t b, time_t now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    buttons_in_i <= b;
    now_ms_i     <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Time mostly creeps forward; sometimes it leaps or lands anywhere.
  task automatic send_rand_poll(btn_t b);
    int r;
    r = $urandom_range(99);
    if (r < 3) t_ms = $urandom();
    else if (r < 10) t_ms = t_ms + $urandom_range(4000, 100);
    else t_ms = t_ms + $urandom_range(25, 0);
    send_poll(b, t_ms);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  task automatic set_config(logic [15:0] direct, logic [15:0] pulse, logic [15:0] hold,
                            logic [15:0] turbo, logic [15:0] menu);
    write_reg(CFG_COIN_DIRECT, direct);
    write_reg(CFG_COIN_PULSE, pulse);
    write_reg(CFG_RESET_HOLD, hold);
    write_reg(CFG_TURBO_PERIOD, turbo);
    write_reg(CFG_MENU_ENABLE, menu);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Bursts hold one button combination with a little noise, so the coin,
  // hold and turbo logic see long presses; some bursts hold a random combination.
  task automatic run_random(int n_polls);
    int   sent;
    int   len;
    btn_t held;
    btn_t b;
    sent = 0;
    while (sent < n_polls) begin
      len = $urandom_range(30, 3);
      case ($urandom_range(9))
        0, 1: held = btn_t'(1 << BTN_EXTRA);
        2, 3: held = btn_t'((1 << BTN_START) | (1 << BTN_EXTRA));
        4:    held = btn_t'((1 << BTN_COIN) | $urandom_range(3));
        5, 6: held = btn_t'((1 << BTN_FIRE) | ($urandom_range(3) << 2));
        7:    held = '0;
        default: held = btn_t'($urandom());
      endcase
      for (int k = 0; k < len && sent < n_polls; k++) begin
        b = held;
        if ($urandom_range(7) == 0) b[$urandom_range(7)] = ~b[$urandom_range(7)];
        if ($urandom_range(15) == 0) b = btn_t'($urandom());
        send_rand_poll(b);
        sent++;
      end
    end
  endtask

  initial begin
    btn_t se;
    se = btn_t'((1 << BTN_START) | (1 << BTN_EXTRA));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Defaults after reset: coin pulse, volume, hold timer, turbo, time wrap.
    send_poll(8'h00, 32'd0);
    send_poll(btn_t'(1 << BTN_EXTRA), 32'd10);
    send_poll(btn_t'(1 << BTN_EXTRA), 32'd100);
    send_poll(btn_t'(1 << BTN_EXTRA), 32'd211);
    send_poll(8'h00, 32'd220);
    send_poll(btn_t'((1 << BTN_COIN) | (1 << BTN_UP)), 32'd230);
    send_poll(btn_t'((1 << BTN_COIN) | (1 << BTN_DOWN)), 32'd240);
    send_poll(btn_t'(1 << BTN_COIN), 32'd250);
    send_poll(se, 32'd260);
    send_poll(se | btn_t'((1 << BTN_COIN) | (1 << BTN_UP)), 32'd1000);
    send_poll(se, 32'd4001);
    send_poll(se, 32'd4100);
    send_poll(8'h00, 32'd4200);
    send_poll(btn_t'(1 << BTN_FIRE), 32'd4210);
    send_poll(btn_t'(1 << BTN_FIRE), 32'd4230);
    send_poll(btn_t'(1 << BTN_FIRE), 32'd4260);
    send_poll(btn_t'(1 << BTN_FIRE), 32'd4310);
    send_poll(8'hFF, 32'hFFFF_FFF0);
    send_poll(8'hFF, 32'h0000_0010);
    send_poll(8'h00, 32'hFFFF_FFFF);
    wait_idle();

    // Direct coins, menu off, zero turbo period; upper data bits are dropped.
    set_config(16'h0003, 16'h0000, 16'h0000, 16'hFC00, 16'hFFFE);
    send_poll(btn_t'(1 << BTN_FIRE), 32'd500);
    send_poll(btn_t'(1 << BTN_FIRE), 32'd500);
    send_poll(btn_t'(1 << BTN_FIRE), 32'd500);
    send_poll(se, 32'd600);
    send_poll(se, 32'd9000);
    send_poll(btn_t'(1 << BTN_COIN), 32'd9001);
    wait_idle();

    // Zero hold and pulse times need one elapsed millisecond.
    set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
    send_poll(se, 32'd700);
    send_poll(se, 32'd700);
    send_poll(se, 32'd701);
    send_poll(8'h00, 32'd702);
    send_poll(btn_t'(1 << BTN_EXTRA), 32'd800);
    send_poll(btn_t'(1 << BTN_EXTRA), 32'd800);
    send_poll(btn_t'(1 << BTN_EXTRA), 32'd801);
    wait_idle();

    t_ms = 32'd1000;
    for (int p = 0; p < N_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      case (p)
        0: set_config(16'h0000, 16'h0000, 16'h0000, 16'hFC00, 16'h0001);
        1: set_config(16'h0000, 16'hFFFF, 16'hFFFF, 16'h03FF, 16'h0001);
        2: set_config(16'h0001, 16'($urandom_range(300)), 16'($urandom_range(400)),
                      16'($urandom_range(60, 1)), 16'h0000);
        default: set_config(16'($urandom_range(1)), 16'($urandom_range(300)),
                            16'($urandom_range(400)), 16'($urandom_range(60, 1)),
                            16'($urandom_range(3) != 0));
      endcase
      // The block fills up and stalls its input while the receiver holds off.
      if (p == 4) holds_asked++;
      run_random(PHASE_POLLS / 2);
      wait_idle();
      run_random(PHASE_POLLS - PHASE_POLLS / 2);
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) sb.report_mismatch("predicted results left over at the end");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/abc_pkg.sv
rtl/abc_coin.sv
rtl/abc_ctrl.sv
rtl/abc_turbo.sv
rtl/arcade_button_conditioner_top.sv
test/tb_arcade_button_conditioner_top.sv
